// ===== hw/rtl/pthd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthd_pkg
// Shared types and constants of the pre-order tree Huffman decoder.
// ----------------------------------------------------------------------------
package pthd_pkg;

  localparam int NODE_LIMIT = 512;
  localparam int NODE_W     = $clog2(NODE_LIMIT);
  localparam int CNT_W      = NODE_W + 1;
  localparam int LEN_W      = 24;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERR_END = 2'd2;
  localparam logic [1:0] ST_ERR_BIG = 2'd3;

  typedef struct packed {
    logic       start;
    logic       load;
    logic       tree_bit;
    logic       walk_bit;
    logic       drain_inc;
    logic       pend_set;
    logic [1:0] pend_status;
    logic       pend_root;
    logic       put_pend;
    logic       put_last;
    logic       put_stat;
    logic [1:0] stat_code;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_reached;
    logic len_reached_inc;
    logic root_leaf;
    logic tree_finish;
    logic tree_over;
    logic leaf_hit;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/pthd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthd_datapath
// Node store, parse stack, walk pointer, counters and result register.
// ----------------------------------------------------------------------------
module pthd_datapath import pthd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic [7:0]       in_data_byte,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_has_symbol,
  output logic [7:0]       out_symbol,
  output logic [1:0]       out_status,
  output logic             out_last
);

  logic [NODE_W:0]   zero_mem  [NODE_LIMIT];
  logic [NODE_W:0]   one_mem   [NODE_LIMIT];
  logic [7:0]        sym_mem   [NODE_LIMIT];
  logic [NODE_W:0]   stack_mem [NODE_LIMIT];

  logic [LEN_W-1:0]  out_length_r;
  logic [7:0]        byte_r;
  logic [3:0]        lbl_r, lbl_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [CNT_W-1:0]  nf_r, nf_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [NODE_W:0]   top_r, top_nxt;
  logic              ld_pend_r, ld_pend_nxt;
  logic              root_leaf_r;
  logic [7:0]        root_sym_r;
  logic [NODE_W-1:0] walk_r, walk_nxt;
  logic [LEN_W-1:0]  bytes_r, bytes_nxt, bytes_inc;
  logic              pend_valid_r;
  logic [7:0]        pend_sym_r;
  logic [1:0]        pend_status_r;
  logic              out_valid_r, out_has_r, out_last_r;
  logic [7:0]        out_sym_r;
  logic [1:0]        out_status_r;
  logic [NODE_W:0]   zero_q, one_q, stack_q;
  logic [7:0]        sym_q;

  logic              bit_cur;
  logic [NODE_W-1:0] idx;
  logic [NODE_W:0]   child;
  logic              zero_we, one_we, sym_we, stack_we, stack_re, sym_re, root_we;
  logic [NODE_W-1:0] link_addr, sym_waddr, stack_waddr, stack_raddr, sym_raddr;
  logic [NODE_W:0]   link_data, stack_wdata;

  assign bit_cur   = byte_r[7];
  assign idx       = nf_r[NODE_W-1:0];
  assign child     = bit_cur ? one_q : zero_q;
  assign bytes_inc = bytes_r + 1'b1;

  always_comb begin
    lbl_nxt     = lbl_r;
    shift_nxt   = shift_r;
    nf_nxt      = nf_r;
    depth_nxt   = depth_r;
    top_nxt     = top_r;
    ld_pend_nxt = 1'b0;
    walk_nxt    = walk_r;
    bytes_nxt   = bytes_r;
    zero_we     = 1'b0;
    one_we      = 1'b0;
    sym_we      = 1'b0;
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    sym_re      = 1'b0;
    root_we     = 1'b0;
    link_addr   = top_r[NODE_W:1];
    link_data   = {bit_cur, idx};
    sym_waddr   = idx - 1'b1;
    stack_waddr = depth_r[NODE_W-1:0] - 1'b1;
    stack_wdata = {top_r[NODE_W:1], 1'b1};
    stack_raddr = depth_r[NODE_W-1:0] - 2'd2;
    sym_raddr   = child[NODE_W-1:0];
    if (ld_pend_r) begin
      top_nxt = stack_q;
    end
    if (cmd.start) begin
      lbl_nxt   = '0;
      shift_nxt = '0;
      nf_nxt    = '0;
      depth_nxt = '0;
      walk_nxt  = '0;
      bytes_nxt = '0;
    end else if (cmd.tree_bit) begin
      if (lbl_r != '0) begin
        shift_nxt = {shift_r[6:0], bit_cur};
        lbl_nxt   = lbl_r - 1'b1;
        if (lbl_r == 4'd1) begin
          sym_we = 1'b1;
        end
      end else if (nf_r < CNT_W'(NODE_LIMIT)) begin
        nf_nxt  = nf_r + 1'b1;
        root_we = (nf_r == '0);
        if (bit_cur) begin
          lbl_nxt   = 4'd8;
          shift_nxt = '0;
        end
        if (depth_r == '0) begin
          if (!bit_cur) begin
            top_nxt   = {idx, 1'b0};
            depth_nxt = depth_r + 1'b1;
          end
        end else if (!top_r[0]) begin
          zero_we = 1'b1;
          top_nxt = {top_r[NODE_W:1], 1'b1};
          if (!bit_cur) begin
            stack_we  = 1'b1;
            top_nxt   = {idx, 1'b0};
            depth_nxt = depth_r + 1'b1;
          end
        end else begin
          one_we = 1'b1;
          if (!bit_cur) begin
            top_nxt = {idx, 1'b0};
          end else begin
            depth_nxt = depth_r - 1'b1;
            if (depth_r > CNT_W'(1)) begin
              stack_re    = 1'b1;
              ld_pend_nxt = 1'b1;
            end
          end
        end
      end
    end else if (cmd.walk_bit) begin
      if (child[NODE_W]) begin
        sym_re    = 1'b1;
        bytes_nxt = bytes_inc;
        walk_nxt  = '0;
      end else begin
        walk_nxt = child[NODE_W-1:0];
      end
    end else if (cmd.drain_inc) begin
      bytes_nxt = bytes_inc;
    end
  end

  always_comb begin
    sts.len_zero        = (out_length_r == '0);
    sts.len_reached     = (bytes_r >= out_length_r);
    sts.len_reached_inc = (bytes_inc >= out_length_r);
    sts.root_leaf       = root_leaf_r;
    sts.tree_finish     = cmd.tree_bit && (lbl_r == 4'd1) && (depth_r == '0);
    sts.tree_over       = cmd.tree_bit && (lbl_r == '0) && (nf_r >= CNT_W'(NODE_LIMIT));
    sts.leaf_hit        = cmd.walk_bit && child[NODE_W];
    sts.pend_valid      = pend_valid_r;
    sts.out_free        = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (zero_we && !top_r[0]) begin
      zero_mem[link_addr] <= link_data;
    end
    if (one_we) begin
      one_mem[link_addr] <= link_data;
    end
    if (sym_we) begin
      sym_mem[sym_waddr] <= shift_nxt;
    end
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    zero_q <= zero_mem[walk_nxt];
    one_q  <= one_mem[walk_nxt];
    if (sym_re) begin
      sym_q <= sym_mem[sym_raddr];
    end
    if (stack_re) begin
      stack_q <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_length_r <= '0;
      lbl_r        <= '0;
      shift_r      <= '0;
      nf_r         <= '0;
      depth_r      <= '0;
      ld_pend_r    <= 1'b0;
      walk_r       <= '0;
      bytes_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_length_r <= cfg_wdata;
      end
      lbl_r     <= lbl_nxt;
      shift_r   <= shift_nxt;
      nf_r      <= nf_nxt;
      depth_r   <= depth_nxt;
      ld_pend_r <= ld_pend_nxt && !cmd.start;
      walk_r    <= walk_nxt;
      bytes_r   <= bytes_nxt;
      if (cmd.pend_set) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.put_pend) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.put_pend || cmd.put_stat) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load) begin
      byte_r <= in_data_byte;
    end else if (cmd.tree_bit || cmd.walk_bit) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
    if (root_we) begin
      root_leaf_r <= bit_cur;
    end
    if (sym_we && (sym_waddr == '0)) begin
      root_sym_r <= shift_nxt;
    end
    if (cmd.pend_set) begin
      pend_sym_r    <= cmd.pend_root ? root_sym_r : sym_q;
      pend_status_r <= cmd.pend_status;
    end
    if (cmd.put_pend) begin
      out_has_r    <= 1'b1;
      out_sym_r    <= pend_sym_r;
      out_status_r <= pend_status_r;
      out_last_r   <= cmd.put_last;
    end else if (cmd.put_stat) begin
      out_has_r    <= 1'b0;
      out_sym_r    <= '0;
      out_status_r <= cmd.stat_code;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_symbol = out_has_r;
  assign out_symbol     = out_sym_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

// ===== hw/rtl/pthd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthd_ctrl
// Stream phase and per-transaction bit sequencer of the decoder.
// ----------------------------------------------------------------------------
module pthd_ctrl import pthd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic       in_stream_end,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TREE, PH_WALK, PH_DRAIN, PH_DONE, PH_ERR_END, PH_ERR_BIG
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_SYM, S_DRAIN, S_FIN, S_FIN2, S_STAT
  } state_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] op_r;
  logic       end_r;
  logic       err;

  function automatic logic [1:0] cur_status(phase_t ph);
    logic [1:0] s;
    unique case (ph)
      PH_DONE:    s = ST_DONE;
      PH_ERR_END: s = ST_ERR_END;
      PH_ERR_BIG: s = ST_ERR_BIG;
      default:    s = ST_BUSY;
    endcase
    return s;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign err      = (phase_r == PH_ERR_END) || (phase_r == PH_ERR_BIG);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 4'd8;
          state_nxt = S_FIN;
          if (in_op == OP_START) begin
            cmd.start = 1'b1;
            phase_nxt = sts.len_zero ? PH_DONE : PH_TREE;
          end else if (in_op == OP_BYTE &&
                       (phase_r == PH_TREE || phase_r == PH_WALK)) begin
            state_nxt = S_BIT;
          end else if (in_op == OP_DRAIN && phase_r == PH_DRAIN) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_BIT: begin
        if (phase_r == PH_TREE) begin
          cmd.tree_bit = 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          if (sts.tree_over) begin
            phase_nxt = PH_ERR_BIG;
          end else if (sts.tree_finish) begin
            priority if (sts.len_reached) phase_nxt = PH_DONE;
            else if (sts.root_leaf) phase_nxt = PH_DRAIN;
            else phase_nxt = PH_WALK;
          end
          if (cnt_r == 4'd1 || sts.tree_over ||
              (sts.tree_finish && (sts.len_reached || sts.root_leaf))) begin
            state_nxt = S_FIN;
          end
        end else if (sts.len_reached) begin
          phase_nxt = PH_DONE;
          state_nxt = S_FIN;
        end else begin
          cmd.walk_bit = 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          if (sts.leaf_hit) begin
            state_nxt = S_SYM;
          end else if (cnt_r == 4'd1) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SYM: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.put_pend    = sts.pend_valid;
          cmd.pend_set    = 1'b1;
          cmd.pend_status = sts.len_reached ? ST_DONE : ST_BUSY;
          if (sts.len_reached) begin
            phase_nxt = PH_DONE;
          end
          state_nxt = (cnt_r == '0 || sts.len_reached) ? S_FIN : S_BIT;
        end
      end
      S_DRAIN: begin
        if (sts.len_reached) begin
          phase_nxt = PH_DONE;
          state_nxt = S_FIN;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.drain_inc   = 1'b1;
          cmd.put_pend    = sts.pend_valid;
          cmd.pend_set    = 1'b1;
          cmd.pend_root   = 1'b1;
          cmd.pend_status = sts.len_reached_inc ? ST_DONE : ST_BUSY;
          if (sts.len_reached_inc) begin
            phase_nxt = PH_DONE;
          end
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == 4'd1) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (op_r == OP_BYTE && end_r &&
            (phase_r == PH_TREE || phase_r == PH_WALK)) begin
          phase_nxt = PH_ERR_END;
        end
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (!sts.pend_valid) begin
          state_nxt = S_STAT;
        end else if (sts.out_free) begin
          cmd.put_pend = 1'b1;
          cmd.put_last = !err;
          state_nxt    = err ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.put_stat  = 1'b1;
          cmd.stat_code = cur_status(phase_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      op_r    <= OP_START;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_IDLE && in_valid) begin
        op_r  <= in_op;
        end_r <= in_stream_end;
      end
    end
  end

endmodule

// ===== hw/rtl/preorder_tree_huffman_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preorder_tree_huffman_decoder_core
// Rebuilds a pre-order serialized Huffman tree, then decodes bytes from it.
// ----------------------------------------------------------------------------
// The tree walk takes one compressed bit per cycle but pauses while a decoded
// byte waits on the result register, and stalls on that register delay the
// result. in_stall holds off a new transaction until the current one is done.
// Reset: synchronous active-low rst_n clears control state; node store and
// parse stack are not cleared and need no clearing pass.
module preorder_tree_huffman_decoder_core import pthd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_data_byte,
  input  logic             in_stream_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_has_symbol,
  output logic [7:0]       out_symbol,
  output logic [1:0]       out_status,
  output logic             out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pthd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_stream_end(in_stream_end),
    .cmd          (cmd),
    .sts          (sts)
  );

  pthd_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_data_byte  (in_data_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_has_symbol(out_has_symbol),
    .out_symbol    (out_symbol),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule
